[sv/pwc_pkg.sv]
// Shared types and constants of the pulse width capture FIFO.
package pwc_pkg;

  localparam int WIDTH_W       = 16;
  localparam int OP_W          = 2;
  localparam int DEPTH_DEFAULT = 16;
  // Entries of the command queue between front and back; keep it a power of two.
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [WIDTH_W-1:0] EMPTY_MARK       = 16'hFFFF;
  localparam logic               HALF_SCALE_RESET = 1'b1;

  localparam logic [OP_W-1:0] OP_EDGE        = 2'd0;
  localparam logic [OP_W-1:0] OP_READ_OLDEST = 2'd1;
  localparam logic [OP_W-1:0] OP_READ_NEWEST = 2'd2;

  typedef enum logic [1:0] {
    CMD_EDGE,
    CMD_READ_OLDEST,
    CMD_READ_NEWEST,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [WIDTH_W-1:0]   capture_count;
  } cmd_t;

endpackage

[sv/pwc_if.sv]
// Handshake channels for capture events and pulse width results.
interface pwc_in_if;
  logic                        valid;
  logic                        ready;
  logic [pwc_pkg::OP_W-1:0]    op;
  logic [pwc_pkg::WIDTH_W-1:0] capture_count;

  modport source(output valid, output op, output capture_count, input ready);
  modport sink(input valid, input op, input capture_count, output ready);
endinterface

interface pwc_out_if;
  logic                        valid;
  logic                        ready;
  logic [pwc_pkg::WIDTH_W-1:0] pulse_width;
  logic                        data_found;
  logic                        available;

  modport source(output valid, output pulse_width, output data_found, output available,
                 input ready);
  modport sink(input valid, input pulse_width, input data_found, input available,
               output ready);
endinterface

[sv/pwc_front.sv]
// Front end: accepts input beats, decodes the op and queues commands.
module pwc_front (
  input  logic          clk,
  input  logic          rst,
  pwc_in_if.sink        capture,
  output logic          cmd_valid,
  output pwc_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  localparam int PTR_W = (pwc_pkg::QUEUE_DEPTH > 1) ? $clog2(pwc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pwc_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(pwc_pkg::QUEUE_DEPTH);

  pwc_pkg::cmd_t    queue [pwc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  pwc_pkg::cmd_t    decoded;

  always_comb begin
    decoded.capture_count = capture.capture_count;
    case (capture.op)
      pwc_pkg::OP_EDGE:        decoded.kind = pwc_pkg::CMD_EDGE;
      pwc_pkg::OP_READ_OLDEST: decoded.kind = pwc_pkg::CMD_READ_OLDEST;
      pwc_pkg::OP_READ_NEWEST: decoded.kind = pwc_pkg::CMD_READ_NEWEST;
      default:                 decoded.kind = pwc_pkg::CMD_NOP;
    endcase
  end

  assign capture.ready = (count != FULL_COUNT);
  assign push          = capture.valid && capture.ready;
  assign cmd_valid     = (count != '0);
  assign pop           = cmd_pop && cmd_valid;
  assign cmd           = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[sv/pwc_back.sv]
// Back end: edge pairing, width ring buffer, reads and the result register.
module pwc_back #(
  parameter int DEPTH = pwc_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  pwc_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  pwc_out_if.source     result
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                      state;
  logic                        half_scale;
  logic                        awaiting_falling;
  logic [pwc_pkg::WIDTH_W-1:0] start_count;
  logic [IDX_W-1:0]            write_index;
  logic [IDX_W-1:0]            read_index;
  logic                        found;
  logic [pwc_pkg::WIDTH_W-1:0] width_store [DEPTH];
  logic [pwc_pkg::WIDTH_W-1:0] rd_data;

  logic                        out_valid;
  logic [pwc_pkg::WIDTH_W-1:0] out_width;
  logic                        out_found;
  logic                        out_avail;

  logic                        take;
  logic                        nonempty;
  logic [IDX_W-1:0]            write_adv;
  logic [IDX_W-1:0]            newest_slot;
  logic [IDX_W-1:0]            read_slot;
  logic [IDX_W-1:0]            read_slot_adv;
  logic                        store_we;
  logic [pwc_pkg::WIDTH_W-1:0] new_width;
  logic [pwc_pkg::WIDTH_W-1:0] raw_width;

  assign take          = cmd_valid && (state == S_IDLE) && (!out_valid || result.ready);
  assign cmd_pop       = take;
  assign nonempty      = (read_index != write_index);
  assign write_adv     = (write_index == LAST) ? '0 : write_index + IDX_W'(1);
  assign newest_slot   = (write_index == '0) ? LAST : write_index - IDX_W'(1);
  assign read_slot     = (cmd.kind == pwc_pkg::CMD_READ_NEWEST) ? newest_slot : read_index;
  assign read_slot_adv = (read_slot == LAST) ? '0 : read_slot + IDX_W'(1);
  assign store_we      = take && (cmd.kind == pwc_pkg::CMD_EDGE) && awaiting_falling;
  assign new_width     = cmd.capture_count - start_count;
  assign raw_width     = found ? rd_data : pwc_pkg::EMPTY_MARK;

  assign result.valid       = out_valid;
  assign result.pulse_width = out_width;
  assign result.data_found  = out_found;
  assign result.available   = out_avail;

  // Width store: one write port at the write index, one registered read port.
  always_ff @(posedge clk) begin
    if (store_we) begin
      width_store[write_index] <= new_width;
    end
    rd_data <= width_store[read_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      half_scale       <= pwc_pkg::HALF_SCALE_RESET;
      awaiting_falling <= 1'b0;
      start_count      <= '0;
      write_index      <= '0;
      read_index       <= '0;
      found            <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_scale <= cfg_wdata;
      end
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            case (cmd.kind)
              pwc_pkg::CMD_EDGE: begin
                awaiting_falling <= !awaiting_falling;
                if (!awaiting_falling) begin
                  start_count <= cmd.capture_count;
                end else if (write_adv != read_index) begin
                  write_index <= write_adv;
                end
                out_valid <= 1'b1;
                out_width <= '0;
                out_found <= 1'b0;
                // A falling edge always leaves at least one width stored.
                out_avail <= nonempty || awaiting_falling;
              end
              pwc_pkg::CMD_READ_OLDEST, pwc_pkg::CMD_READ_NEWEST: begin
                found <= nonempty;
                if (nonempty) begin
                  read_index <= read_slot_adv;
                end
                state <= S_READ;
              end
              default: begin
                out_valid <= 1'b1;
                out_width <= '0;
                out_found <= 1'b0;
                out_avail <= nonempty;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          out_width <= half_scale ? (raw_width >> 1) : raw_width;
          out_found <= found;
          out_avail <= nonempty;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result register is always drained before a read finishes.
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !out_valid)
    else $error("read finishing while result register still holds a beat");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (write_index <= LAST) && (read_index <= LAST))
    else $error("ring index out of range");

  a_read_sequence: assert property (@(posedge clk) disable iff (rst)
    take && (cmd.kind == pwc_pkg::CMD_READ_OLDEST || cmd.kind == pwc_pkg::CMD_READ_NEWEST)
      |=> (state == S_READ) && !out_valid)
    else $error("read command did not enter the data phase");

  a_newest_empties: assert property (@(posedge clk) disable iff (rst)
    take && (cmd.kind == pwc_pkg::CMD_READ_NEWEST) |=> (read_index == write_index))
    else $error("read of newest width left entries in the buffer");

endmodule

[sv/pulse_width_capture_fifo_unit.sv]
// Top level of the pulse width capture FIFO: command queue front end and execution back end.
//
//   Channel   Modport  Payload                          Beat taken when
//   capture   sink     op, capture_count                valid && ready
//   result    source   pulse_width, data_found,         valid && ready
//                      available
//   cfg       write    cfg_wdata (half_scale)           cfg_we
//
// The front end takes one beat per cycle into a two-entry command queue while it has room.
// The back end handles an edge or unused op in S_IDLE alone and a read in S_IDLE then S_READ,
// the latter waiting on the registered read port of the width store.
// Synchronous reset clears the queue, the edge pairing, both ring indices and sets
// half_scale; the width store is not cleared, since only written entries are ever read.
// A stalled result register stops the back end; the queue then fills and drops ready.
module pulse_width_capture_fifo_unit #(
  parameter int DEPTH = pwc_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  pwc_in_if.sink    capture,
  pwc_out_if.source result,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic          cmd_valid;
  logic          cmd_pop;
  pwc_pkg::cmd_t cmd;

  pwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .capture   (capture),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  pwc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

endmodule
